### hdl/lsto_pkg.sv
// Shared types, widths and constants for the layer stack track overlap block.
// No dependencies; every other file in hdl/ except lsto_ram imports this package.
package lsto_pkg;

    localparam int DEF_MAX_LAYERS = 8;

    localparam int DEPTH_W  = 18;
    localparam int CENTER_W = 18;
    localparam int SIZE_W   = 17;
    localparam int SLOPE_W  = 20;
    localparam int LEN_W    = 18;
    localparam int CNT_W    = 4;
    localparam int IDX_IN_W = 3;
    localparam int PROD_W   = SLOPE_W + DEPTH_W;
    localparam int FRAC_W   = 12;
    localparam int SHIFT_W  = PROD_W - FRAC_W;
    localparam int BND_W    = 28;
    localparam int ADDR_EXT_W = 7;

    localparam logic [CNT_W-1:0] CFG_RESET = 4'd8;
    localparam logic [LEN_W-1:0] LEN_MAX   = 18'h3FFFF;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic signed [DEPTH_W-1:0]  depth;
        logic signed [CENTER_W-1:0] center;
        logic        [SIZE_W-1:0]   size;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Per-layer control that travels down the pipeline with the data.
    typedef struct packed {
        logic valid;       // slot carries a layer
        logic first;       // layer 0: load the full intersection bounds
        logic odd;         // second layer of a pair: close the hull
        logic pair_first;  // layer 1: load the pair intersection bounds
    } tag_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Length of [lo, hi], zero when empty, saturated at LEN_MAX.
    function automatic logic [LEN_W-1:0] clamp_len(
        input logic signed [BND_W-1:0] lo,
        input logic signed [BND_W-1:0] hi
    );
        logic signed [BND_W:0] diff;
        diff = (BND_W+1)'(hi) - (BND_W+1)'(lo);
        if (diff <= 0)
            return '0;
        else if (diff > $signed((BND_W+1)'(LEN_MAX)))
            return LEN_MAX;
        else
            return diff[LEN_W-1:0];
    endfunction

endpackage

### hdl/lsto_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module lsto_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lsto_interval.sv
// Shared interval unit: slope times depth (registered), then the layer's
// shifted low and high bounds. Depends on lsto_pkg.
module lsto_interval (
    input  logic                               clk,
    input  logic                               rst_n,
    input  lsto_pkg::tag_t                     tag_in,
    input  lsto_pkg::entry_t                   entry,
    input  logic signed [lsto_pkg::SLOPE_W-1:0] slope,
    output lsto_pkg::tag_t                     tag_out,
    output logic signed [lsto_pkg::BND_W-1:0]  lo,
    output logic signed [lsto_pkg::BND_W-1:0]  hi
);
    import lsto_pkg::*;

    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [CENTER_W-1:0] center_reg;
    logic        [SIZE_W-1:0]   size_reg;
    tag_t                       tag_reg;
    logic signed [SHIFT_W-1:0]  shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_W'(slope) * PROD_W'(entry.depth);
        center_reg <= entry.center;
        size_reg   <= entry.size;
    end

    // Arithmetic shift right by the fraction bits: floor of the product.
    assign shift = prod_reg[PROD_W-1:FRAC_W];

    assign lo = BND_W'(center_reg) - BND_W'(size_reg >> 1) - BND_W'(shift);
    assign hi = lo + BND_W'(size_reg);
    assign tag_out = tag_reg;

endmodule

### hdl/lsto_accum.sv
// Running bounds of the full intersection and of the pair-hull intersection,
// and the clamped lengths taken from them. Depends on lsto_pkg.
module lsto_accum (
    input  logic                              clk,
    input  lsto_pkg::tag_t                    tag,
    input  logic signed [lsto_pkg::BND_W-1:0] lo,
    input  logic signed [lsto_pkg::BND_W-1:0] hi,
    input  logic [lsto_pkg::CNT_W-1:0]        layer_cnt,
    output logic [lsto_pkg::LEN_W-1:0]        len_all,
    output logic [lsto_pkg::LEN_W-1:0]        len_pairs
);
    import lsto_pkg::*;

    logic signed [BND_W-1:0] amin_reg, amax_reg;
    logic signed [BND_W-1:0] pmin_reg, pmax_reg;
    logic signed [BND_W-1:0] prv_lo_reg, prv_hi_reg;
    logic signed [BND_W-1:0] hull_lo, hull_hi;

    assign hull_lo = (lo < prv_lo_reg) ? lo : prv_lo_reg;
    assign hull_hi = (hi > prv_hi_reg) ? hi : prv_hi_reg;

    always_ff @(posedge clk)
    begin
        if (tag.valid)
        begin
            if (tag.first || lo > amin_reg)
                amin_reg <= lo;
            if (tag.first || hi < amax_reg)
                amax_reg <= hi;
            if (!tag.odd)
            begin
                prv_lo_reg <= lo;
                prv_hi_reg <= hi;
            end
            else
            begin
                if (tag.pair_first || hull_lo > pmin_reg)
                    pmin_reg <= hull_lo;
                if (tag.pair_first || hull_hi < pmax_reg)
                    pmax_reg <= hull_hi;
            end
        end
    end

    assign len_all   = (layer_cnt != '0) ? clamp_len(amin_reg, amax_reg) : '0;
    assign len_pairs = (layer_cnt >= CNT_W'(2)) ? clamp_len(pmin_reg, pmax_reg) : '0;

endmodule

### hdl/layer_stack_track_overlap.sv
// Top level of the layer stack track overlap block: sequencer, layer table
// and entry valid bits. Depends on lsto_pkg, lsto_ram, lsto_interval, lsto_accum.
//
// A load (req_type 0) writes one layer entry in a single cycle and gives no
// result; busy stays low. A query (req_type 1) walks the n layers in use
// (n = layers_in_use, capped at MAX_LAYERS) through one shared multiplier and
// interval unit, one layer per cycle, then holds busy while the pipeline
// tail drains (n zero goes straight to S_DONE) and raises done for a single
// cycle right after busy drops, with overlap_all and overlap_pairs valid in
// that cycle. The result is held until the next query ends; capture it on
// done. A new item may start in the done cycle. The layer table clears at
// reset through per-entry valid bits, so no clearing pass is needed.
// layers_in_use may only be written while busy is low.
module layer_stack_track_overlap #(
    parameter int MAX_LAYERS = lsto_pkg::DEF_MAX_LAYERS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // command channel
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [lsto_pkg::IDX_IN_W-1:0]        layer_index,
    input  logic signed [lsto_pkg::DEPTH_W-1:0]  layer_depth,
    input  logic signed [lsto_pkg::CENTER_W-1:0] layer_center,
    input  logic [lsto_pkg::SIZE_W-1:0]          layer_size,
    input  logic signed [lsto_pkg::SLOPE_W-1:0]  slope,
    // result strobe
    output logic                                 done,
    output logic [lsto_pkg::LEN_W-1:0]           overlap_all,
    output logic [lsto_pkg::LEN_W-1:0]           overlap_pairs,
    // configuration write channel (layers_in_use)
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lsto_pkg::CNT_W-1:0]           cfg_data
);
    import lsto_pkg::*;

    localparam int IDX_W = $clog2(MAX_LAYERS);

    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            cfg_reg;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic signed [SLOPE_W-1:0]   slope_reg;
    logic [MAX_LAYERS-1:0]       ent_vld_reg;
    tag_t                        tag1_reg;
    logic                        vld1_reg;
    logic                        done_reg;
    logic [LEN_W-1:0]            all_reg, pairs_reg;

    logic                        accept;
    logic                        load_ok;
    logic [CNT_W-1:0]            n_eff;
    logic [ADDR_EXT_W-1:0]       widx_ext, ridx_ext;
    logic [IDX_W-1:0]            waddr, raddr;
    logic [ENTRY_W-1:0]          rdata;
    entry_t                      wentry, rentry;
    tag_t                        tag0, tag2;
    logic signed [BND_W-1:0]     lo, hi;
    logic [LEN_W-1:0]            len_all, len_pairs;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Clip the configured count to the table size.
    assign n_eff = (ADDR_EXT_W'(cfg_reg) > ADDR_EXT_W'(MAX_LAYERS))
                 ? CNT_W'(MAX_LAYERS) : cfg_reg;

    // Drop loads that point past the table.
    assign widx_ext = ADDR_EXT_W'(layer_index);
    assign load_ok  = accept && (req_type == REQ_LOAD)
                   && (widx_ext < ADDR_EXT_W'(MAX_LAYERS));
    assign waddr    = widx_ext[IDX_W-1:0];
    assign ridx_ext = ADDR_EXT_W'(cnt_reg);
    assign raddr    = ridx_ext[IDX_W-1:0];

    assign wentry.depth  = layer_depth;
    assign wentry.center = layer_center;
    assign wentry.size   = layer_size;

    lsto_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_LAYERS)
    ) u_table (
        .clk   (clk),
        .we    (load_ok),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (rdata)
    );

    // An entry never written since reset reads as all zeros.
    assign rentry = vld1_reg ? entry_t'(rdata) : '0;

    // Tag for the layer issued this cycle.
    assign tag0.valid      = (state_reg == S_RUN);
    assign tag0.first      = (cnt_reg == '0);
    assign tag0.odd        = cnt_reg[0];
    assign tag0.pair_first = (cnt_reg == CNT_W'(1));

    lsto_interval u_interval (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag1_reg),
        .entry   (rentry),
        .slope   (slope_reg),
        .tag_out (tag2),
        .lo      (lo),
        .hi      (hi)
    );

    lsto_accum u_accum (
        .clk       (clk),
        .tag       (tag2),
        .lo        (lo),
        .hi        (hi),
        .layer_cnt (n_reg),
        .len_all   (len_all),
        .len_pairs (len_pairs)
    );

    // Sequencer: issue one layer a cycle, let the pipeline drain, then
    // present the result.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req_type == REQ_QUERY)
                    state_next = (n_eff == '0) ? S_DONE : S_RUN;
            end
            S_RUN:
            begin
                if (cnt_reg == CNT_W'(n_reg - CNT_W'(1)))
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!tag1_reg.valid && !tag2.valid)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cfg_reg     <= CFG_RESET;
            ent_vld_reg <= '0;
            tag1_reg    <= '0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
            n_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            tag1_reg  <= tag0;
            done_reg  <= (state_reg == S_DONE);
            if (cfg_valid && cfg_ready)
                cfg_reg <= cfg_data;
            if (load_ok)
                ent_vld_reg[waddr] <= 1'b1;
            if (state_reg == S_IDLE && accept && req_type == REQ_QUERY)
            begin
                n_reg   <= n_eff;
                cnt_reg <= '0;
            end
            else if (state_reg == S_RUN)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    // Payload registers: slope, entry valid flag beside RAM data, result.
    always_ff @(posedge clk)
    begin
        if (accept && req_type == REQ_QUERY)
            slope_reg <= slope;
        vld1_reg <= ent_vld_reg[raddr];
        if (state_reg == S_DONE)
        begin
            all_reg   <= len_all;
            pairs_reg <= len_pairs;
        end
    end

    assign done          = done_reg;
    assign overlap_all   = all_reg;
    assign overlap_pairs = pairs_reg;

endmodule

### hdl/lsto_chk.sv
// Port-level checker for layer_stack_track_overlap, bound to the top level.
// Depends on lsto_pkg.
module lsto_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          req_type,
    input logic                          done,
    input logic                          cfg_ready
);
    import lsto_pkg::*;

    // A load transfer leaves the block idle and produces no result.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_LOAD) |=> (!busy && !done))
        else $error("load produced busy or a result");

    // A query transfer makes the block busy.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && req_type == REQ_QUERY) |=> busy)
        else $error("query did not raise busy");

    // A query ends with exactly one result strobe as busy drops.
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // The result strobe is a single-cycle pulse while the block is free.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result strobe malformed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("config channel not ready");

endmodule

bind layer_stack_track_overlap lsto_chk u_lsto_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .done      (done),
    .cfg_ready (cfg_ready)
);
